>>> hdl/bie_pkg.sv
// Shared types and constants for the bitmask immediate encoder.
// No dependencies; imported by the classifier and the top level.
`default_nettype none

package bie_pkg;

	localparam int unsigned REG_W   = 64;
	localparam int unsigned HALF_W  = 32;
	localparam int unsigned FIELD_W = 6;
	localparam int unsigned COUNT_W = 7;

	typedef struct packed {
		logic               encodable;
		logic               n_bit;
		logic [FIELD_W-1:0] rotate_right;
		logic [FIELD_W-1:0] size_and_ones;
	} bie_result_t;

endpackage

`default_nettype wire

>>> hdl/bie_classify.sv
// Combinational classifier: finds the element size, checks for one rotated run of ones
// and forms the N, immr and imms fields. Depends on bie_pkg.
`default_nettype none

module bie_classify import bie_pkg::*; (
	input  wire logic [REG_W-1:0] value,
	input  wire logic             wide,
	output bie_result_t           result
);

	logic [REG_W-1:0]   v;
	logic [REG_W-1:0]   elem_mask;
	logic [REG_W-1:0]   starts;
	logic [REG_W-1:0]   starts_el;
	logic [FIELD_W-1:0] emask;
	logic [FIELD_W-1:0] start_pos;
	logic [COUNT_W-1:0] ones;
	logic [FIELD_W-1:0] ones_m1;
	logic               single;

	assign v = wide ? value : {value[HALF_W-1:0], value[HALF_W-1:0]};

	// The element shrinks while both of its halves agree.
	always_comb begin
		if (v[31:0] != v[63:32]) begin
			emask = 6'd63;
		end else if (v[15:0] != v[31:16]) begin
			emask = 6'd31;
		end else if (v[7:0] != v[15:8]) begin
			emask = 6'd15;
		end else if (v[3:0] != v[7:4]) begin
			emask = 6'd7;
		end else if (v[1:0] != v[3:2]) begin
			emask = 6'd3;
		end else begin
			emask = 6'd1;
		end
	end

	always_comb begin
		for (int i = 0; i < REG_W; i++) begin
			elem_mask[i] = ((FIELD_W'(i) & ~emask) == '0);
		end
	end

	// A bit starts a run when it is set and the bit below it is clear. Because the
	// value repeats with the element's period, bit 63 stands below bit 0.
	assign starts    = v & ~{v[REG_W-2:0], v[REG_W-1]};
	assign starts_el = starts & elem_mask;
	assign single    = (starts_el != '0) && ((starts_el & (starts_el - 1'b1)) == '0);

	always_comb begin
		start_pos = '0;
		ones      = '0;
		for (int i = 0; i < REG_W; i++) begin
			if (starts_el[i]) begin
				start_pos = start_pos | FIELD_W'(i);
			end
			ones = ones + COUNT_W'(v[i] & elem_mask[i]);
		end
	end

	assign ones_m1 = FIELD_W'(ones - 1'b1);

	always_comb begin
		result = '0;
		if (single) begin
			result.encodable     = 1'b1;
			result.n_bit         = (emask == 6'd63);
			result.rotate_right  = (6'd0 - start_pos) & emask;
			result.size_and_ones = ~{emask[FIELD_W-2:0], 1'b1} | ones_m1;
		end
	end

endmodule

`default_nettype wire

>>> hdl/bitmask_immediate_encoder_core.sv
// Top level of the bitmask immediate encoder: input register, classifier, result register.
// Depends on bie_pkg and bie_classify.
`default_nettype none

//  channel | handshake                       | payload
//  --------+---------------------------------+-----------------------------------------
//  input   | in_valid, in_stall (driven here)| value, wide
//  output  | out_valid, out_stall            | encodable, n_bit, rotate_right,
//          |                                 | size_and_ones
//
// A word accepted into the input register goes through the combinational classifier, and its
// result is captured in the result register, which drives the output channel.
// One word is accepted per cycle while the output is not stalled.
// Reset clears both valid flags; payload registers are not reset.
// A stalled result holds; the input register still takes a word while it is empty.

module bitmask_immediate_encoder_core import bie_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [REG_W-1:0]   value,
	input  wire logic               wide,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic                    encodable,
	output logic                    n_bit,
	output logic [FIELD_W-1:0]      rotate_right,
	output logic [FIELD_W-1:0]      size_and_ones
);

	logic             valid_s1;
	logic [REG_W-1:0] value_s1;
	logic             wide_s1;
	logic             valid_s2;
	bie_result_t      result_s2;
	bie_result_t      result_c;
	logic             load_s1;
	logic             load_s2;

	assign load_s2  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !load_s2;
	assign load_s1  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_s1 || load_s2) begin
				valid_s1 <= load_s1;
			end
			if (load_s2) begin
				valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			value_s1 <= value;
			wide_s1  <= wide;
		end
		if (load_s2) begin
			result_s2 <= result_c;
		end
	end

	bie_classify u_classify (
		.value  (value_s1),
		.wide   (wide_s1),
		.result (result_c)
	);

	assign out_valid     = valid_s2;
	assign encodable     = result_s2.encodable;
	assign n_bit         = result_s2.n_bit;
	assign rotate_right  = result_s2.rotate_right;
	assign size_and_ones = result_s2.size_and_ones;

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && in_stall |=> valid_s1 && $stable(value_s1) && $stable(wide_s1))
		else $error("input register lost a stalled word");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !encodable |-> !n_bit && rotate_right == '0 && size_and_ones == '0)
		else $error("rejected word carries nonzero fields");

	a_n_only_wide: assert property (@(posedge clk) disable iff (!arst_n)
		load_s2 && result_c.n_bit |-> wide_s1)
		else $error("N set for a 32-bit operand");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s2 && out_stall)
		else $error("input stalled without a stalled result");

endmodule

`default_nettype wire

>>> dv/tb.sv
// Testbench for bitmask_immediate_encoder_core: directed and random words checked
// against an in-bench encoder, with random idling, output hold-off and a drain pause.
// Depends on bie_pkg and the RTL of the encoder only.
`timescale 1ns / 100ps

module tb import bie_pkg::*; ();

	localparam int unsigned STALL_LIMIT = 4000;
	localparam int unsigned MAX_REPORTS = 10;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [REG_W-1:0]   value = '0;
	logic               wide = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic               encodable;
	logic               n_bit;
	logic [FIELD_W-1:0] rotate_right;
	logic [FIELD_W-1:0] size_and_ones;

	bie_result_t pending_encodings[$];
	int unsigned mismatch_count = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned hold_left = 0;
	int unsigned quiet_cycles = 0;

	bitmask_immediate_encoder_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.value(value),
		.wide(wide),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.encodable(encodable),
		.n_bit(n_bit),
		.rotate_right(rotate_right),
		.size_and_ones(size_and_ones)
	);

	always #4 clk = ~clk;

	function automatic logic [63:0] low_mask(int unsigned n);
		return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
	endfunction

	function automatic logic [63:0] rotr_elem(logic [63:0] x, int unsigned r, int unsigned e);
		logic [63:0] m;
		m = low_mask(e);
		x = x & m;
		if (r == 0 || r >= e)
			return x;
		return ((x >> r) | (x << (e - r))) & m;
	endfunction

	function automatic bie_result_t encode_bitmask(logic [63:0] v_in, logic wide_in);
		logic [63:0] v, m, elem, hm, imms_full;
		int unsigned e, h, ones, r, rot;
		logic hit;
		bie_result_t res;
		res = '0;
		hit = 1'b0;
		rot = 0;
		v = wide_in ? v_in : {v_in[31:0], v_in[31:0]};
		e = 64;
		while (e > 2) begin
			h = e / 2;
			hm = low_mask(h);
			if ((v & hm) != ((v >> h) & hm))
				break;
			e = h;
		end
		m = low_mask(e);
		elem = v & m;
		if (elem == '0 || elem == m)
			return res;
		ones = $countones(elem);
		for (r = 0; r < e; r++) begin
			if (!hit && rotr_elem(low_mask(ones), r, e) == elem) begin
				hit = 1'b1;
				rot = r;
			end
		end
		if (!hit)
			return res;
		imms_full = ~(64'(2 * e - 1)) | 64'(ones - 1);
		res.encodable = 1'b1;
		res.n_bit = (e == 64);
		res.rotate_right = rot[FIELD_W-1:0];
		res.size_and_ones = imms_full[FIELD_W-1:0];
		return res;
	endfunction

	// Called just after a rising edge; returns at the rising edge that accepts the word.
	task automatic send_word(input logic [63:0] v, input logic w);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		value <= v;
		wide <= w;
		do
			@(posedge clk);
		while (in_stall);
		pending_encodings.push_back(encode_bitmask(v, w));
	endtask

	task automatic random_word(output logic [63:0] v, output logic w);
		int unsigned kind, lg, e, ones, rot, i;
		logic [63:0] elem;
		w = 1'($urandom_range(1));
		kind = $urandom_range(99);
		if (kind >= 85) begin
			v = {$urandom, $urandom};
			if (kind == 97)
				v = '0;
			else if (kind == 98)
				v = '1;
			else if (kind == 99)
				v = {$urandom, 32'h0};
			return;
		end
		lg = w ? $urandom_range(6, 1) : $urandom_range(5, 1);
		e = 1 << lg;
		ones = $urandom_range(e - 1, 1);
		rot = $urandom_range(e - 1, 0);
		elem = rotr_elem(low_mask(ones), rot, e);
		v = '0;
		for (i = 0; i < 64; i += e)
			v = v | (elem << i);
		if (!w && $urandom_range(1))
			v[63:32] = $urandom;
		if (kind >= 70) begin
			i = $urandom_range(63);
			v[i] = ~v[i];
		end
		if (kind >= 78) begin
			i = $urandom_range(63);
			v[i] = ~v[i];
		end
	endtask

	task automatic run_directed_words();
		send_word(64'h0, 1'b0);
		send_word(64'h0, 1'b1);
		send_word('1, 1'b0);
		send_word('1, 1'b1);
		send_word(64'h0000_0000_FFFF_FFFF, 1'b0);
		send_word(64'hFFFF_FFFF_0000_0000, 1'b0);
		send_word(64'hFFFF_FFFF_0000_0000, 1'b1);
		send_word(64'h5555_5555_5555_5555, 1'b1);
		send_word(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
		send_word(64'h0000_0000_0000_0001, 1'b1);
		send_word(64'h0000_0000_0000_0001, 1'b0);
		send_word(64'h8000_0000_0000_0000, 1'b1);
		send_word(64'h0000_0000_8000_0000, 1'b0);
		send_word(64'h7FFF_FFFF_FFFF_FFFF, 1'b1);
		send_word(64'hFFFF_FFFF_FFFF_FFFE, 1'b1);
		send_word(64'h1234_5678_8000_0001, 1'b0);
		send_word(64'h0000_0000_0000_0005, 1'b1);
		send_word(64'h0000_0000_0000_0101, 1'b1);
		send_word(64'h00FF_00FF_00FF_00FF, 1'b1);
		send_word(64'hDEAD_BEEF_0F0F_0F0F, 1'b0);
		send_word(64'h0000_0001_0000_0001, 1'b1);
		send_word(64'h8000_0000_0000_0001, 1'b1);
		send_word(64'h3333_3333_3333_3333, 1'b1);
		send_word(64'hFFFF_FFFF_7FFF_FFFE, 1'b0);
	endtask

	task automatic run_random_words(input int unsigned count);
		logic [63:0] v;
		logic w;
		repeat (count) begin
			random_word(v, w);
			send_word(v, w);
		end
	endtask

	// The receiver holds off while words keep coming, so the block fills and stalls its input.
	task automatic run_output_holdoff();
		hold_left = 200;
		run_random_words(40);
	endtask

	// The sender stops until every word in flight has produced its result.
	task automatic run_drain_pause();
		run_random_words(20);
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_encodings.size() != 0)
			@(posedge clk);
		run_random_words(20);
	endtask

	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin : check_results
		bie_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_encodings.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("unexpected result word: enc=%0b n=%0b immr=%0d imms=%0d",
						encodable, n_bit, rotate_right, size_and_ones);
			end else begin
				want = pending_encodings.pop_front();
				if (encodable !== want.encodable || n_bit !== want.n_bit ||
						rotate_right !== want.rotate_right ||
						size_and_ones !== want.size_and_ones) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS) begin
						$write("mismatch: expected enc=%0b n=%0b immr=%0d imms=%0d, ",
							want.encodable, want.n_bit, want.rotate_right,
							want.size_and_ones);
						$display("got enc=%0b n=%0b immr=%0d imms=%0d",
							encodable, n_bit, rotate_right, size_and_ones);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		send_idle_pct = 22;
		recv_stall_pct = 74;
		run_directed_words();
		run_random_words(600);

		send_idle_pct = 74;
		recv_stall_pct = 22;
		run_random_words(560);
		run_drain_pause();

		send_idle_pct = 0;
		recv_stall_pct = 0;
		run_random_words(560);
		run_output_holdoff();

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_encodings.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && pending_encodings.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

>>> filelist.f
hdl/bie_pkg.sv
hdl/bie_classify.sv
hdl/bitmask_immediate_encoder_core.sv
dv/tb.sv
